// ----- rtl/hcbp_pkg.sv -----
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Shared constants, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

   localparam int MAX_CODE_LEN = 32;
   localparam int SYMBOL_COUNT = 256;

   localparam int SYMBOL_W = 8;
   localparam int CODE_W   = 32;
   localparam int LEN_W    = 6;
   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int PEND_W   = BYTE_W - 1;
   localparam int CNT_W    = 3;
   localparam int BUF_W    = CODE_W + BYTE_W;
   localparam int TOTAL_W  = 6;
   localparam int ENTRY_W  = CODE_W + LEN_W;
   localparam int SYM_AW   = $clog2(SYMBOL_COUNT);
   localparam int REQ_W    = 48;

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

   typedef struct packed {
      logic write_entry;
      logic read_entry;
      logic merge;
      logic pop;
      logic finish;
      logic flush_out;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic has_byte;
      logic last_byte;
      logic pending_nonzero;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/hcbp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hcbp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Huffman code bit packer controller
// Sequences table loads, lookups, byte emission and flushes.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [hcbp_pkg::CMD_W-1:0]   req_command,
   input  wire hcbp_pkg::dp_status_type      status,
   output hcbp_pkg::dp_cmd_type              cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOOKUP = 4'b0010,
      ST_EMIT   = 4'b0100,
      ST_FLUSH  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  hcbp_pkg::CMD_LOAD: begin
                     cmd.write_entry = 1'b1;
                  end
                  hcbp_pkg::CMD_ENCODE: begin
                     cmd.read_entry = 1'b1;
                     state_in       = ST_LOOKUP;
                  end
                  hcbp_pkg::CMD_FLUSH: begin
                     if (status.pending_nonzero) begin
                        state_in = ST_FLUSH;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            cmd.merge = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.has_byte) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.out_free) begin
               cmd.pop = 1'b1;
               if (status.last_byte) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.flush_out = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hcbp_datapath.sv -----
// ----------------------------------------------------------------------------
// Huffman code bit packer datapath
// Code table, bit buffer, pending bits and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hcbp_pkg::dp_cmd_type          cmd,
   output hcbp_pkg::dp_status_type            status,
   input  wire logic [hcbp_pkg::SYMBOL_W-1:0] req_symbol,
   input  wire logic [hcbp_pkg::CODE_W-1:0]   req_code_value,
   input  wire logic [hcbp_pkg::LEN_W-1:0]    req_code_length,
   input  wire logic                          rsp_tready,
   output logic                               rsp_tvalid,
   output logic      [hcbp_pkg::BYTE_W-1:0]   rsp_byte,
   output logic                               rsp_last
);

   logic                               valid_ff [hcbp_pkg::SYMBOL_COUNT];
   logic                               hit_ff;
   logic [hcbp_pkg::BUF_W-1:0]         buf_ff;
   logic [hcbp_pkg::BUF_W-1:0]         buf_in;
   logic [hcbp_pkg::TOTAL_W-1:0]       total_ff;
   logic [hcbp_pkg::TOTAL_W-1:0]       total_in;
   logic [hcbp_pkg::PEND_W-1:0]        pend_ff;
   logic [hcbp_pkg::CNT_W-1:0]         pcount_ff;
   logic                               out_valid_ff;
   logic [hcbp_pkg::BYTE_W-1:0]        out_byte_ff;
   logic                               out_last_ff;

   logic                               sym_ok;
   logic [hcbp_pkg::SYM_AW-1:0]        sym_addr;
   logic [hcbp_pkg::LEN_W-1:0]         len_clamped;
   logic [hcbp_pkg::ENTRY_W-1:0]       rd_data;
   logic [hcbp_pkg::CODE_W-1:0]        rd_value;
   logic [hcbp_pkg::LEN_W-1:0]         len_eff;
   logic [hcbp_pkg::CODE_W-1:0]        code_al;
   logic [hcbp_pkg::BUF_W-1:0]         merged;
   logic [hcbp_pkg::BUF_W-1:0]         buf_next;
   logic [hcbp_pkg::TOTAL_W-1:0]       total_next;

   assign sym_ok   = 32'(req_symbol) < 32'(hcbp_pkg::SYMBOL_COUNT);
   assign sym_addr = req_symbol[hcbp_pkg::SYM_AW-1:0];
   assign len_clamped = (req_code_length > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN)) ?
                        hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN) : req_code_length;

   hcbp_ram #(
      .WIDTH (hcbp_pkg::ENTRY_W),
      .DEPTH (hcbp_pkg::SYMBOL_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.write_entry & sym_ok),
      .wr_addr (sym_addr),
      .wr_data ({len_clamped, req_code_value}),
      .rd_en   (cmd.read_entry),
      .rd_addr (sym_addr),
      .rd_data (rd_data)
   );

   assign rd_value = rd_data[hcbp_pkg::CODE_W-1:0];
   assign len_eff  = hit_ff ? rd_data[hcbp_pkg::ENTRY_W-1:hcbp_pkg::CODE_W] : '0;
   assign code_al  = (len_eff == '0) ? '0 :
                     rd_value << (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - len_eff);
   assign merged   = {pend_ff, {(hcbp_pkg::BUF_W - hcbp_pkg::PEND_W){1'b0}}} |
                     ({code_al, {hcbp_pkg::BYTE_W{1'b0}}} >> pcount_ff);

   assign buf_next   = cmd.pop ? (buf_ff << hcbp_pkg::BYTE_W) : buf_ff;
   assign total_next = cmd.pop ? (total_ff - hcbp_pkg::TOTAL_W'(hcbp_pkg::BYTE_W)) : total_ff;

   always_comb begin
      buf_in   = buf_next;
      total_in = total_next;
      if (cmd.merge) begin
         buf_in   = merged;
         total_in = hcbp_pkg::TOTAL_W'(pcount_ff) + len_eff;
      end
   end

   assign status.out_free        = ~out_valid_ff | rsp_tready;
   assign status.has_byte        = total_ff >= hcbp_pkg::TOTAL_W'(hcbp_pkg::BYTE_W);
   assign status.last_byte       = total_ff < hcbp_pkg::TOTAL_W'(2 * hcbp_pkg::BYTE_W);
   assign status.pending_nonzero = pcount_ff != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hcbp_pkg::SYMBOL_COUNT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (cmd.write_entry && sym_ok) begin
         valid_ff[sym_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_entry) begin
         hit_ff <= sym_ok & valid_ff[sym_addr];
      end
      buf_ff <= buf_in;
      if (cmd.pop) begin
         out_byte_ff <= buf_ff[hcbp_pkg::BUF_W-1 -: hcbp_pkg::BYTE_W];
         out_last_ff <= status.last_byte;
      end else if (cmd.flush_out) begin
         out_byte_ff <= {pend_ff, 1'b0};
         out_last_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         pend_ff      <= '0;
         pcount_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         total_ff <= total_in;
         if (cmd.finish) begin
            pend_ff   <= buf_next[hcbp_pkg::BUF_W-1 -: hcbp_pkg::PEND_W];
            pcount_ff <= total_next[hcbp_pkg::CNT_W-1:0];
         end else if (cmd.flush_out) begin
            pend_ff   <= '0;
            pcount_ff <= '0;
         end
         if (cmd.pop || cmd.flush_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_byte   = out_byte_ff;
   assign rsp_last   = out_last_ff;

endmodule

`default_nettype wire

// ----- rtl/huffman_code_bit_packer.sv -----
// ----------------------------------------------------------------------------
// Huffman code bit packer
// Table-driven Huffman encoder that packs codes most significant bit first.
// ----------------------------------------------------------------------------
// The request channel carries one command word at a time: load writes a code
// table entry, encode appends the code of a symbol to the pending bits and
// flush pads the pending bits with zeros and sends them as a final byte.
// Each full byte leaves on the response channel, and the last byte caused by
// a request word carries rsp_tlast. A load, an empty code or an empty flush
// sends nothing.
// Requests are taken one at a time. An encode reads the table entry in a
// registered read, merges the code into the bit buffer and then moves each
// full byte to the output register, which sends one byte per cycle while
// the receiver accepts them; an encode sends up to 4 bytes. A flush with
// bits pending moves them to the output register as one byte.
// When the receiver stalls, the output register holds its word and the
// packer waits; no byte is lost. Reset clears the table to zero length, the
// pending bits and the output register, and the block is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // symbol[7:0], code_value[39:8], code_length[45:40], zero[47:46]
   input  wire logic [hcbp_pkg::REQ_W-1:0]  req_tdata,
   // command[1:0]
   input  wire logic [hcbp_pkg::CMD_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // packed_byte[7:0]
   output logic      [hcbp_pkg::BYTE_W-1:0] rsp_tdata,
   output logic                             rsp_tlast
);

   hcbp_pkg::dp_cmd_type    cmd;
   hcbp_pkg::dp_status_type status;

   hcbp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser),
      .status      (status),
      .cmd         (cmd)
   );

   hcbp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_symbol      (req_tdata[7:0]),
      .req_code_value  (req_tdata[39:8]),
      .req_code_length (req_tdata[45:40]),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_byte        (rsp_tdata),
      .rsp_last        (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- rtl/hcbp_checker.sv -----
// ----------------------------------------------------------------------------
// Huffman code bit packer checker
// Port-level assertions on the packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tvalid,
   input wire logic                        req_tready,
   input wire logic [hcbp_pkg::CMD_W-1:0]  req_tuser,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [hcbp_pkg::BYTE_W-1:0] rsp_tdata,
   input wire logic                        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response word changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == hcbp_pkg::CMD_LOAD && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("table load produced a byte");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a run of bytes");

   a_busy_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken while a run is unfinished");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
